[src/fgap_pkg.sv]
// Package for the largest free identifier gap finder: widths, codes and shared types.
`default_nettype none
package fgap_pkg;

    localparam int ID_W        = 32;
    localparam int MAX_IDS_DEF = 256;
    localparam int ADDR_W      = 3;

    // Register index as decoded from paddr[2]
    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_RNG  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } fgap_state_t;

    // Broadcast to every cell of the sorted chain
    typedef struct packed
    {
        logic            ins;
        logic            shl;
        logic [ID_W-1:0] key;
    } fgap_cell_ctl_t;

    // Control of the gap tracker at the head of the chain
    typedef struct packed
    {
        logic init;
        logic step;
        logic guard;
    } fgap_scan_ctl_t;

endpackage
`default_nettype wire

[src/fgap_cell.sv]
// One cell of the sorted identifier chain: holds one value, inserts in order, shifts to head.
`default_nettype none
module fgap_cell
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire fgap_pkg::fgap_cell_ctl_t ctl,
    input  wire                           left_valid,
    input  wire                           left_gt,
    input  wire  [fgap_pkg::ID_W-1:0]     left_val,
    input  wire                           right_valid,
    input  wire  [fgap_pkg::ID_W-1:0]     right_val,
    output logic                          valid,
    output logic                          gt,
    output logic [fgap_pkg::ID_W-1:0]     val
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [fgap_pkg::ID_W-1:0] val_reg;
    logic [fgap_pkg::ID_W-1:0] val_next;

    // Own compare, also handed to the right neighbor
    assign gt    = valid_reg && (val_reg > ctl.key);
    assign valid = valid_reg;
    assign val   = val_reg;

    always_comb
    begin
        valid_next = valid_reg;
        val_next   = val_reg;
        if (ctl.shl)
        begin
            valid_next = right_valid;
            val_next   = right_val;
        end
        else if (ctl.ins)
        begin
            if (left_gt)
            begin
                // larger values move one place right
                valid_next = 1'b1;
                val_next   = left_val;
            end
            else if (left_valid && (gt || !valid_reg))
            begin
                // first value above the key, or first empty cell, takes the key
                valid_next = 1'b1;
                val_next   = ctl.key;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

[src/fgap_scan.sv]
// Gap tracker: walks values leaving the chain head and keeps the widest free run.
`default_nettype none
module fgap_scan
(
    input  wire                           clk,
    input  wire fgap_pkg::fgap_scan_ctl_t ctl,
    input  wire  [fgap_pkg::ID_W-1:0]     head_val,
    input  wire  [fgap_pkg::ID_W-1:0]     range_low,
    input  wire  [fgap_pkg::ID_W-1:0]     range_high,
    output logic [fgap_pkg::ID_W-1:0]     left_next,
    output logic [fgap_pkg::ID_W-1:0]     right_next
);

    localparam int PW = fgap_pkg::ID_W + 2;   // prev spans low-1 .. high+1
    localparam int DW = fgap_pkg::ID_W + 1;   // distance cur - prev

    logic [PW-1:0]             prev_reg;
    logic [PW-1:0]             prev_next;
    logic [DW-1:0]             bestd_reg;
    logic [DW-1:0]             bestd_next;
    logic [fgap_pkg::ID_W-1:0] left_reg;
    logic [fgap_pkg::ID_W-1:0] right_reg;
    logic [PW-1:0]             cur;
    logic [PW-1:0]             diff;
    logic                      in_rng;
    logic                      better;

    always_comb
    begin
        if (ctl.guard)
        begin
            cur    = {2'b00, range_high} + PW'(1);
            in_rng = 1'b1;
        end
        else
        begin
            cur    = {2'b00, head_val};
            in_rng = (head_val >= range_low) && (head_val <= range_high);
        end
        diff   = cur - prev_reg;
        // values arrive ascending, so diff is never negative; gap = diff - 1
        better = (diff[DW-1:0] > bestd_reg);

        prev_next  = prev_reg;
        bestd_next = bestd_reg;
        left_next  = left_reg;
        right_next = right_reg;
        if (ctl.init)
        begin
            prev_next  = {2'b00, range_low} - PW'(1);
            bestd_next = '0;
        end
        else if (ctl.step && in_rng)
        begin
            prev_next = cur;
            if (better)
            begin
                bestd_next = diff[DW-1:0];
                left_next  = prev_reg[fgap_pkg::ID_W-1:0] + fgap_pkg::ID_W'(1);
                right_next = cur[fgap_pkg::ID_W-1:0] - fgap_pkg::ID_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg  <= prev_next;
        bestd_reg <= bestd_next;
        left_reg  <= left_next;
        right_reg <= right_next;
    end

endmodule
`default_nettype wire

[src/largest_free_id_gap_finder.sv]
// Top level of the largest free identifier gap finder: config port, cell chain, gap scan.
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  -------------------------------
//  item      in         start && !busy             id_present, used_id, last_item
//  result    out        done (one-cycle strobe)    gap_left, gap_right, status
//  config    in         psel&penable&pwrite        paddr, pwdata -> prdata, pready
//
//  Items transfer one per cycle while not busy; an in-range ID is sorted into the cell
//  chain in that same cycle unless it is full (one compare per cell against the broadcast
//  key). After a last item, busy stays high while the chain shifts its values one a cycle
//  into the gap tracker and the guard closes the walk; done follows on the next cycle.
//  Reset (rst_n low, asynchronous) empties the chain, clears overflow, sets the range to
//  the full 32-bit span. The receiver cannot stall: each result shows for one cycle.
`default_nettype none
module largest_free_id_gap_finder
#(
    parameter int MAX_IDS = fgap_pkg::MAX_IDS_DEF
)
(
    input  wire                             clk,
    input  wire                             rst_n,
    // config port
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [fgap_pkg::ADDR_W-1:0]     paddr,
    input  wire  [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // item channel
    input  wire                             start,
    output logic                            busy,
    input  wire                             id_present,
    input  wire  [fgap_pkg::ID_W-1:0]       used_id,
    input  wire                             last_item,
    // result channel
    output logic                            done,
    output logic [fgap_pkg::ID_W-1:0]       gap_left,
    output logic [fgap_pkg::ID_W-1:0]       gap_right,
    output logic [1:0]                      status
);

    localparam int W = fgap_pkg::ID_W;

    fgap_pkg::fgap_state_t     state_reg;
    fgap_pkg::fgap_state_t     state_next;
    logic [W-1:0]              range_low_reg;
    logic [W-1:0]              range_high_reg;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic                      done_reg;
    logic                      done_next;
    logic [W-1:0]              gap_left_reg;
    logic [W-1:0]              gap_left_next;
    logic [W-1:0]              gap_right_reg;
    logic [W-1:0]              gap_right_next;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;

    logic                      accept;
    logic                      in_rng;
    logic                      full;
    logic                      finish;
    logic                      cfg_wr;
    fgap_pkg::fgap_cell_ctl_t  cell_ctl;
    fgap_pkg::fgap_scan_ctl_t  scan_ctl;
    logic [W-1:0]              scan_left;
    logic [W-1:0]              scan_right;

    logic [MAX_IDS-1:0]        cell_valid;
    logic [MAX_IDS-1:0]        cell_gt;
    logic [W-1:0]              cell_val [MAX_IDS];

    // ---------------- config registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            fgap_pkg::REG_RANGE_LOW:  prdata = range_low_reg;
            default:                  prdata = range_high_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= '1;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                fgap_pkg::REG_RANGE_LOW:  range_low_reg  <= pwdata;
                default:                  range_high_reg <= pwdata;
            endcase
        end
    end

    // ---------------- control ----------------
    assign busy   = (state_reg == fgap_pkg::ST_SCAN);
    assign accept = start && !busy;
    assign in_rng = id_present && (used_id >= range_low_reg) && (used_id <= range_high_reg);
    assign full   = cell_valid[MAX_IDS-1];
    // chain head empty while scanning: the upper guard closes the walk
    assign finish = busy && !cell_valid[0];

    assign cell_ctl.ins = accept && in_rng && !full;
    assign cell_ctl.shl = busy && cell_valid[0];
    assign cell_ctl.key = used_id;

    assign scan_ctl.init  = accept && last_item;
    assign scan_ctl.step  = busy;
    assign scan_ctl.guard = !cell_valid[0];

    always_comb
    begin
        state_next     = state_reg;
        ovf_next       = ovf_reg;
        done_next      = 1'b0;
        gap_left_next  = gap_left_reg;
        gap_right_next = gap_right_reg;
        status_next    = status_reg;
        case (state_reg)
            fgap_pkg::ST_IDLE:
            begin
                if (accept && in_rng && full)
                begin
                    ovf_next = 1'b1;
                end
                if (accept && last_item)
                begin
                    state_next = fgap_pkg::ST_SCAN;
                end
            end
            fgap_pkg::ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = fgap_pkg::ST_IDLE;
                    done_next  = 1'b1;
                    ovf_next   = 1'b0;
                    if (range_low_reg >= range_high_reg)
                    begin
                        gap_left_next  = '0;
                        gap_right_next = '0;
                        status_next    = fgap_pkg::STAT_BAD_RNG;
                    end
                    else
                    begin
                        gap_left_next  = scan_left;
                        gap_right_next = scan_right;
                        status_next    = ovf_reg ? fgap_pkg::STAT_OVERFLOW : fgap_pkg::STAT_OK;
                    end
                end
            end
            default:
            begin
                state_next = fgap_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fgap_pkg::ST_IDLE;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gap_left_reg  <= gap_left_next;
        gap_right_reg <= gap_right_next;
        status_reg    <= status_next;
    end

    assign done      = done_reg;
    assign gap_left  = gap_left_reg;
    assign gap_right = gap_right_reg;
    assign status    = status_reg;

    // ---------------- sorted cell chain ----------------
    for (genvar i = 0; i < MAX_IDS; i++)
    begin : g_cell
        logic          lv;
        logic          lg;
        logic [W-1:0]  lval;
        logic          rv;
        logic [W-1:0]  rval;

        if (i == 0)
        begin : g_head
            // virtual left neighbor below every value
            assign lv   = 1'b1;
            assign lg   = 1'b0;
            assign lval = '0;
        end
        else
        begin : g_mid
            assign lv   = cell_valid[i-1];
            assign lg   = cell_gt[i-1];
            assign lval = cell_val[i-1];
        end

        if (i == MAX_IDS - 1)
        begin : g_tail
            assign rv   = 1'b0;
            assign rval = '0;
        end
        else
        begin : g_body
            assign rv   = cell_valid[i+1];
            assign rval = cell_val[i+1];
        end

        fgap_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .left_valid  (lv),
            .left_gt     (lg),
            .left_val    (lval),
            .right_valid (rv),
            .right_val   (rval),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i]),
            .val         (cell_val[i])
        );
    end

    // ---------------- gap tracker ----------------
    fgap_scan u_scan
    (
        .clk        (clk),
        .ctl        (scan_ctl),
        .head_val   (cell_val[0]),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .left_next  (scan_left),
        .right_next (scan_right)
    );

endmodule
`default_nettype wire

[src/fgap_checker.sv]
// Port-level checks for the gap finder, bound to its top level.
`default_nettype none
module fgap_port_checks
(
    input wire                          clk,
    input wire                          rst_n,
    input wire                          start,
    input wire                          busy,
    input wire                          last_item,
    input wire                          done,
    input wire [fgap_pkg::ID_W-1:0]     gap_left,
    input wire [fgap_pkg::ID_W-1:0]     gap_right,
    input wire [1:0]                    status
);

    // a last item starts the walk
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_item) |=> busy)
        else $error("walk did not start after last item");

    // a result only closes a walk
    a_done_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result outside end of walk");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3))
        else $error("undefined status code");

    a_bad_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == fgap_pkg::STAT_BAD_RNG)) |-> (gap_left == '0 && gap_right == '0))
        else $error("invalid range result not zero");

endmodule

bind largest_free_id_gap_finder fgap_port_checks u_fgap_port_checks
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_item (last_item),
    .done      (done),
    .gap_left  (gap_left),
    .gap_right (gap_right),
    .status    (status)
);
`default_nettype wire
